/* hdl/cvu_pkg.sv */
// Shared constants, types and the arctangent table of the CORDIC vector unit.
// Used by the CORDIC stage chain, the top level and the testbench.
`timescale 1ns / 1ps

package cvu_pkg;

    localparam int ITERATION_LIMIT = 23;
    localparam int N_ITER          = ITERATION_LIMIT - 1;
    localparam int W               = 34;   // datapath width of x and y
    localparam int TW              = 27;   // datapath width of the angle

    localparam logic [2:0] OP_ROTATE = 3'd0;
    localparam logic [2:0] OP_ATAN   = 3'd1;
    localparam logic [2:0] OP_LENGTH = 3'd2;
    localparam logic [2:0] OP_COS    = 3'd3;
    localparam logic [2:0] OP_SIN    = 3'd4;

    localparam logic signed [TW-1:0] DEG_Q4   = 27'sd2949120;
    localparam logic signed [TW-1:0] DEG_Q2   = 27'sd5898240;
    localparam logic signed [TW-1:0] DEG_HALF = 27'sd11796480;

    localparam logic [31:0]         SHRINK   = 32'hDBD95B16;
    localparam logic signed [W-1:0] COS_SEED = 34'sd14408027;
    localparam logic [4:0]          NORM_MSB = 5'd29;

    typedef struct packed {
        logic signed [W-1:0]  x;
        logic signed [W-1:0]  y;
        logic signed [TW-1:0] theta;
        logic                 vec;
    } t_vec;

    typedef struct packed {
        logic [2:0]  op;
        logic        bypass;
        logic        dn;
        logic [4:0]  sh;
        logic [31:0] bp_first;
        logic [31:0] bp_second;
    } t_side;

    function automatic logic signed [TW-1:0] arc(input logic [4:0] idx);
        logic signed [TW-1:0] a;
        case (idx)
            5'd0:  a = 27'sd1740967;
            5'd1:  a = 27'sd919879;
            5'd2:  a = 27'sd466945;
            5'd3:  a = 27'sd234379;
            5'd4:  a = 27'sd117304;
            5'd5:  a = 27'sd58666;
            5'd6:  a = 27'sd29335;
            5'd7:  a = 27'sd14668;
            5'd8:  a = 27'sd7334;
            5'd9:  a = 27'sd3667;
            5'd10: a = 27'sd1833;
            5'd11: a = 27'sd917;
            5'd12: a = 27'sd458;
            5'd13: a = 27'sd229;
            5'd14: a = 27'sd115;
            5'd15: a = 27'sd57;
            5'd16: a = 27'sd29;
            5'd17: a = 27'sd14;
            5'd18: a = 27'sd7;
            5'd19: a = 27'sd4;
            5'd20: a = 27'sd2;
            5'd21: a = 27'sd1;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

/* hdl/cvu_if.sv */
// Valid/ready channel interfaces for the items entering and leaving the unit.
// Self-contained; widths follow the item fields.
`timescale 1ns / 1ps

interface cvu_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         operation;
    logic signed [30:0] point_x;
    logic signed [30:0] point_y;
    logic signed [25:0] angle;

    modport source(output valid, operation, point_x, point_y, angle, input ready);
    modport sink(input valid, operation, point_x, point_y, angle, output ready);
endinterface

interface cvu_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result_first;
    logic signed [31:0] result_second;

    modport source(output valid, result_first, result_second, input ready);
    modport sink(input valid, result_first, result_second, output ready);
endinterface

/* hdl/cvu_cordic.sv */
// Chain of pipelined CORDIC pseudo-rotation stages, one register stage each.
// Depends on cvu_pkg for the datapath types and the arctangent table.
`timescale 1ns / 1ps

module cvu_cordic (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  cvu_pkg::t_vec  i_data,
    input  cvu_pkg::t_side i_side,
    output logic           o_valid,
    output cvu_pkg::t_vec  o_data,
    output cvu_pkg::t_side o_side
);

    logic [cvu_pkg::N_ITER-1:0] r_v;
    cvu_pkg::t_vec              r_d [cvu_pkg::N_ITER];
    cvu_pkg::t_side             r_s [cvu_pkg::N_ITER];

    for (genvar g = 0; g < cvu_pkg::N_ITER; g++) begin : g_stage
        localparam logic signed [cvu_pkg::W-1:0] RND = cvu_pkg::W'(1) << g;

        logic           w_src_v;
        cvu_pkg::t_vec  w_src;
        cvu_pkg::t_side w_src_s;
        cvu_pkg::t_vec  n_d;

        if (g == 0) begin : g_first
            assign w_src_v = i_valid;
            assign w_src   = i_data;
            assign w_src_s = i_side;
        end else begin : g_next
            assign w_src_v = r_v[g-1];
            assign w_src   = r_d[g-1];
            assign w_src_s = r_s[g-1];
        end

        always_comb begin
            logic signed [cvu_pkg::W-1:0] dx;
            logic signed [cvu_pkg::W-1:0] dy;
            logic                         up;
            dx  = (w_src.y + RND) >>> (g + 1);
            dy  = (w_src.x + RND) >>> (g + 1);
            // Vectoring drives y to zero, rotation drives the angle to zero.
            up  = w_src.vec ? (!w_src.y[cvu_pkg::W-1] && (w_src.y != '0))
                            : w_src.theta[cvu_pkg::TW-1];
            n_d = w_src;
            if (up) begin
                n_d.x     = w_src.x + dx;
                n_d.y     = w_src.y - dy;
                n_d.theta = w_src.theta + cvu_pkg::arc(5'(g));
            end else begin
                n_d.x     = w_src.x - dx;
                n_d.y     = w_src.y + dy;
                n_d.theta = w_src.theta - cvu_pkg::arc(5'(g));
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (i_en) begin
                r_v[g] <= w_src_v;
            end
            if (i_en) begin
                r_d[g] <= n_d;
                r_s[g] <= w_src_s;
            end
        end
    end

    assign o_valid = r_v[cvu_pkg::N_ITER-1];
    assign o_data  = r_d[cvu_pkg::N_ITER-1];
    assign o_side  = r_s[cvu_pkg::N_ITER-1];

endmodule

/* hdl/cordic_vector_unit.sv */
// CORDIC vector unit: rotate, arctangent, length, cosine and sine in 16.16 degrees.
// It takes one item per cycle unless the output stalls, and runs it through four
// front stages (decode, leading-one search, normalizing shift, quadrant move), 22
// CORDIC stages and three back stages (gain multiply, rounding, denormalizing shift).
// When the result is not taken the whole pipeline holds, so nothing is lost.
// Depends on cvu_pkg, cvu_if and cvu_cordic.
`timescale 1ns / 1ps

module cordic_vector_unit (
    input logic     i_clk,
    input logic     i_rst_n,
    cvu_in_if.sink  i_in,
    cvu_out_if.source o_out
);

    typedef struct packed {
        cvu_pkg::t_side side;
        cvu_pkg::t_vec  v;
        logic           norm;
        logic [30:0]    m;
    } t_front;

    logic w_en;

    logic   r_p0_valid, r_p1_valid, r_p2_valid, r_p3_valid;
    t_front r_p0, r_p1, r_p2, n_p0, n_p1, n_p2;
    cvu_pkg::t_vec  r_p3_v, n_p3_v;
    cvu_pkg::t_side r_p3_s;

    logic           w_c_valid;
    cvu_pkg::t_vec  w_c;
    cvu_pkg::t_side w_cs;

    logic           r_q1_valid, r_q2_valid, r_q3_valid;
    cvu_pkg::t_side r_q1_s, r_q2_s;
    logic           r_q1_nx, r_q1_ny;
    logic [63:0]    r_q1_px, r_q1_py;
    logic [31:0]    r_q1_r1, r_q2_r1, n_q1_r1;
    logic signed [cvu_pkg::W-1:0] r_q2_x, r_q2_y, n_q2_x, n_q2_y;
    logic [31:0]    r_q3_first, r_q3_second, n_q3_first, n_q3_second;
    logic [2:0]     r_q3_op;

    assign w_en       = !r_q3_valid || o_out.ready;
    assign i_in.ready = w_en;

    // Decode.
    always_comb begin
        logic [30:0] mx;
        logic [30:0] my;
        logic        zp;
        mx = i_in.point_x[30] ? (~i_in.point_x + 31'd1) : i_in.point_x;
        my = i_in.point_y[30] ? (~i_in.point_y + 31'd1) : i_in.point_y;
        zp = (i_in.point_x == '0) && (i_in.point_y == '0);
        n_p0 = '0;
        n_p0.side.op = i_in.operation;
        n_p0.m       = mx | my;
        n_p0.v.x     = {{3{i_in.point_x[30]}}, i_in.point_x};
        n_p0.v.y     = {{3{i_in.point_y[30]}}, i_in.point_y};
        n_p0.v.theta = {i_in.angle[25], i_in.angle};
        case (i_in.operation)
            cvu_pkg::OP_ROTATE: begin
                n_p0.norm           = 1'b1;
                n_p0.side.bypass    = (i_in.angle == '0) || zp;
                n_p0.side.bp_first  = {i_in.point_x[30], i_in.point_x};
                n_p0.side.bp_second = {i_in.point_y[30], i_in.point_y};
            end
            cvu_pkg::OP_ATAN: begin
                n_p0.norm        = 1'b1;
                n_p0.v.vec       = 1'b1;
                n_p0.side.bypass = zp;
            end
            cvu_pkg::OP_LENGTH: begin
                n_p0.norm          = 1'b1;
                n_p0.v.vec         = 1'b1;
                n_p0.side.bypass   = (i_in.point_x == '0) || (i_in.point_y == '0);
                n_p0.side.bp_first = (i_in.point_x == '0) ? {1'b0, my} : {1'b0, mx};
            end
            cvu_pkg::OP_COS: begin
                n_p0.v.x = cvu_pkg::COS_SEED;
                n_p0.v.y = '0;
            end
            cvu_pkg::OP_SIN: begin
                n_p0.v.x     = cvu_pkg::COS_SEED;
                n_p0.v.y     = '0;
                n_p0.v.theta = cvu_pkg::DEG_Q2 - {i_in.angle[25], i_in.angle};
            end
            default: begin
                n_p0.side.bypass = 1'b1;
            end
        endcase
    end

    // Leading-one search for the normalizing shift.
    always_comb begin
        logic [4:0] top;
        top = '0;
        for (int k = 0; k < 31; k++) begin
            if (r_p0.m[k]) begin
                top = 5'(k);
            end
        end
        n_p1 = r_p0;
        if (r_p0.norm) begin
            if (top > cvu_pkg::NORM_MSB) begin
                n_p1.side.dn = 1'b1;
            end else begin
                n_p1.side.sh = cvu_pkg::NORM_MSB - top;
            end
        end
    end

    always_comb begin
        n_p2 = r_p1;
        if (r_p1.side.dn) begin
            n_p2.v.x = r_p1.v.x >>> 1;
            n_p2.v.y = r_p1.v.y >>> 1;
        end else begin
            n_p2.v.x = r_p1.v.x <<< r_p1.side.sh;
            n_p2.v.y = r_p1.v.y <<< r_p1.side.sh;
        end
    end

    // Quadrant move: quarter turns for rotation, sector fold for vectoring.
    always_comb begin
        logic signed [cvu_pkg::W-1:0]  x;
        logic signed [cvu_pkg::W-1:0]  y;
        logic signed [cvu_pkg::W-1:0]  t;
        logic signed [cvu_pkg::TW-1:0] th;
        x  = r_p2.v.x;
        y  = r_p2.v.y;
        t  = '0;
        th = r_p2.v.theta;
        if (r_p2.v.vec) begin
            if (y > x) begin
                if (y > -x) begin
                    t = y; y = -x; x = t; th = cvu_pkg::DEG_Q2;
                end else begin
                    th = (y > 0) ? cvu_pkg::DEG_HALF : -cvu_pkg::DEG_HALF;
                    x  = -x;
                    y  = -y;
                end
            end else begin
                if (y < -x) begin
                    th = -cvu_pkg::DEG_Q2; t = -y; y = x; x = t;
                end else begin
                    th = '0;
                end
            end
        end else begin
            for (int k = 0; k < 5; k++) begin
                if (th < -cvu_pkg::DEG_Q4) begin
                    t = y; y = -x; x = t; th = th + cvu_pkg::DEG_Q2;
                end else if (th > cvu_pkg::DEG_Q4) begin
                    t = -y; y = x; x = t; th = th - cvu_pkg::DEG_Q2;
                end
            end
        end
        n_p3_v       = r_p2.v;
        n_p3_v.x     = x;
        n_p3_v.y     = y;
        n_p3_v.theta = th;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p0_valid <= 1'b0;
            r_p1_valid <= 1'b0;
            r_p2_valid <= 1'b0;
            r_p3_valid <= 1'b0;
        end else if (w_en) begin
            r_p0_valid <= i_in.valid;
            r_p1_valid <= r_p0_valid;
            r_p2_valid <= r_p1_valid;
            r_p3_valid <= r_p2_valid;
        end
        if (w_en) begin
            r_p0   <= n_p0;
            r_p1   <= n_p1;
            r_p2   <= n_p2;
            r_p3_v <= n_p3_v;
            r_p3_s <= r_p2.side;
        end
    end

    cvu_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_p3_valid),
        .i_data  (r_p3_v),
        .i_side  (r_p3_s),
        .o_valid (w_c_valid),
        .o_data  (w_c),
        .o_side  (w_cs)
    );

    // Angle rounding, cosine scaling, and the magnitudes for the gain multiply.
    always_comb begin
        logic signed [cvu_pkg::TW-1:0] t;
        logic signed [cvu_pkg::W-1:0]  c;
        t = w_c.theta;
        if (!t[cvu_pkg::TW-1]) begin
            t = (t + 27'sd16) & ~27'sd31;
        end else begin
            t = -((-t + 27'sd16) & ~27'sd31);
        end
        c = (w_c.x + 34'sd128) >>> 8;
        if (w_cs.op == cvu_pkg::OP_ATAN) begin
            n_q1_r1 = {{5{t[cvu_pkg::TW-1]}}, t};
        end else begin
            n_q1_r1 = c[31:0];
        end
    end

    always_comb begin
        logic [32:0] sx;
        logic [32:0] sy;
        sx = {1'b0, r_q1_px[63:32]} + 33'd1;
        sy = {1'b0, r_q1_py[63:32]} + 33'd1;
        n_q2_x = r_q1_nx ? -$signed({1'b0, sx}) : $signed({1'b0, sx});
        n_q2_y = r_q1_ny ? -$signed({1'b0, sy}) : $signed({1'b0, sy});
    end

    // Denormalize with rounding and pick the result.
    always_comb begin
        logic signed [cvu_pkg::W-1:0] h;
        logic signed [cvu_pkg::W-1:0] rx;
        logic signed [cvu_pkg::W-1:0] ry;
        h = (cvu_pkg::W'(1) << r_q2_s.sh) >>> 1;
        if (r_q2_s.dn) begin
            rx = r_q2_x <<< 1;
            ry = r_q2_y <<< 1;
        end else if (r_q2_s.sh != '0) begin
            if (r_q2_s.op == cvu_pkg::OP_ROTATE) begin
                rx = $signed(r_q2_x + h - cvu_pkg::W'(r_q2_x[cvu_pkg::W-1])) >>> r_q2_s.sh;
                ry = $signed(r_q2_y + h - cvu_pkg::W'(r_q2_y[cvu_pkg::W-1])) >>> r_q2_s.sh;
            end else begin
                rx = (r_q2_x + h) >>> r_q2_s.sh;
                ry = (r_q2_y + h) >>> r_q2_s.sh;
            end
        end else begin
            rx = r_q2_x;
            ry = r_q2_y;
        end
        n_q3_first  = '0;
        n_q3_second = '0;
        if (r_q2_s.bypass) begin
            n_q3_first  = r_q2_s.bp_first;
            n_q3_second = r_q2_s.bp_second;
        end else begin
            case (r_q2_s.op)
                cvu_pkg::OP_ROTATE: begin
                    n_q3_first  = rx[31:0];
                    n_q3_second = ry[31:0];
                end
                cvu_pkg::OP_LENGTH: n_q3_first = rx[31:0];
                default:            n_q3_first = r_q2_r1;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q1_valid <= 1'b0;
            r_q2_valid <= 1'b0;
            r_q3_valid <= 1'b0;
        end else if (w_en) begin
            r_q1_valid <= w_c_valid;
            r_q2_valid <= r_q1_valid;
            r_q3_valid <= r_q2_valid;
        end
        if (w_en) begin
            r_q1_s  <= w_cs;
            r_q1_nx <= w_c.x[cvu_pkg::W-1];
            r_q1_ny <= w_c.y[cvu_pkg::W-1];
            r_q1_px <= 64'(w_c.x[cvu_pkg::W-1] ? 32'(-w_c.x) : w_c.x[31:0])
                       * 64'(cvu_pkg::SHRINK);
            r_q1_py <= 64'(w_c.y[cvu_pkg::W-1] ? 32'(-w_c.y) : w_c.y[31:0])
                       * 64'(cvu_pkg::SHRINK);
            r_q1_r1 <= n_q1_r1;
            r_q2_s  <= r_q1_s;
            r_q2_x  <= n_q2_x;
            r_q2_y  <= n_q2_y;
            r_q2_r1 <= r_q1_r1;
            r_q3_first  <= n_q3_first;
            r_q3_second <= n_q3_second;
            r_q3_op     <= r_q2_s.op;
        end
    end

    assign o_out.valid         = r_q3_valid;
    assign o_out.result_first  = r_q3_first;
    assign o_out.result_second = r_q3_second;

    a_second_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_q3_valid && (r_q3_op != cvu_pkg::OP_ROTATE) |-> r_q3_second == '0)
        else $error("second result nonzero for a non-rotate item");

    a_atan_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_q3_valid && (r_q3_op == cvu_pkg::OP_ATAN) |-> r_q3_first[4:0] == '0)
        else $error("arctangent not on its rounding grid");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_p0_valid) && $stable(r_q1_valid) && $stable(w_c_valid))
        else $error("pipeline advanced during a stall");

endmodule

/* sim/cordic_vector_unit_test.sv */
// Self-checking testbench of cordic_vector_unit: directed and random items of every operation,
// results checked in order against a bit-exact CORDIC predictor, with bursty input and stalls.
// Depends on cvu_pkg, cvu_if and the unit itself.
`timescale 1ns / 1ps

module cordic_vector_unit_test;

    localparam longint ARC_Q4   = 64'sd2949120;
    localparam longint ARC_Q2   = 64'sd5898240;
    localparam longint ARC_HALF = 64'sd11796480;
    localparam longint TURN     = 64'sd23592960;
    localparam longint unsigned GAIN = 64'hDBD95B16;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct {
        logic [2:0] op;
        longint     x;
        longint     y;
        longint     ang;
    } t_query;

    typedef struct {
        logic [31:0] first;
        logic [31:0] second;
    } t_answer;

    logic clk;
    logic rst_n;
    cvu_in_if  in_if();
    cvu_out_if out_if();

    cordic_vector_unit uut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    t_query  query_q[$];
    t_answer answer_q[$];
    t_query  cur_query;
    int      errors = 0;
    int      accepted = 0;
    longint  cycles = 0;

    longint atab[22] = '{1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                         14668, 7334, 3667, 1833, 917, 458, 229, 115,
                         57, 29, 14, 7, 4, 2, 1};

    function automatic longint magn(longint v);
        return v < 0 ? -v : v;
    endfunction

    // Scales the point so its larger magnitude has its top bit at 29; returns the up-shift.
    function automatic int norm_point(ref longint x, ref longint y);
        longint unsigned m;
        int top;
        m = longint'(magn(x)) | longint'(magn(y));
        top = 0;
        for (int k = 0; k < 63; k++)
            if (m[k]) top = k;
        if (top <= 29) begin
            x = x <<< (29 - top);
            y = y <<< (29 - top);
            return 29 - top;
        end
        x = x >>> (top - 29);
        y = y >>> (top - 29);
        return -(top - 29);
    endfunction

    function automatic longint gain_fix(longint v);
        longint unsigned t;
        longint s;
        t = longint'(magn(v)) * GAIN + 64'h1_0000_0000;
        s = longint'(t >> 32);
        return v < 0 ? -s : s;
    endfunction

    function automatic void rot_iter(ref longint x, ref longint y, input longint theta);
        longint t, dx, dy;
        while (theta < -ARC_Q4) begin t = y; y = -x; x = t; theta += ARC_Q2; end
        while (theta > ARC_Q4) begin t = -y; y = x; x = t; theta -= ARC_Q2; end
        for (int i = 1; i <= 22; i++) begin
            dx = (y + (64'sd1 <<< (i - 1))) >>> i;
            dy = (x + (64'sd1 <<< (i - 1))) >>> i;
            if (theta < 0) begin x += dx; y -= dy; theta += atab[i-1]; end
            else begin x -= dx; y += dy; theta -= atab[i-1]; end
        end
    endfunction

    function automatic longint vec_iter(ref longint x, input longint y);
        longint theta, t, dx, dy;
        if (y > x) begin
            if (y > -x) begin t = y; y = -x; x = t; theta = ARC_Q2; end
            else begin theta = y > 0 ? ARC_HALF : -ARC_HALF; x = -x; y = -y; end
        end else begin
            if (y < -x) begin theta = -ARC_Q2; t = -y; y = x; x = t; end
            else theta = 0;
        end
        for (int i = 1; i <= 22; i++) begin
            dx = (y + (64'sd1 <<< (i - 1))) >>> i;
            dy = (x + (64'sd1 <<< (i - 1))) >>> i;
            if (y > 0) begin x += dx; y -= dy; theta += atab[i-1]; end
            else begin x -= dx; y += dy; theta -= atab[i-1]; end
        end
        // Round to a multiple of 32, half away from zero.
        if (theta >= 0) theta = (theta + 16) & ~64'sd31;
        else theta = -((-theta + 16) & ~64'sd31);
        return theta;
    endfunction

    function automatic longint cos_value(longint a);
        longint x, y;
        x = longint'(GAIN >> 8);
        y = 0;
        rot_iter(x, y, a);
        return (x + 64'sd128) >>> 8;
    endfunction

    function automatic t_answer cordic_predict(t_query q);
        longint r1, r2, x, y, h, dummy;
        int s;
        t_answer a;
        r1 = 0;
        r2 = 0;
        x = q.x;
        y = q.y;
        case (q.op)
            cvu_pkg::OP_ROTATE: begin
                if (q.ang == 0 || (q.x == 0 && q.y == 0)) begin
                    r1 = q.x; r2 = q.y;
                end else begin
                    s = norm_point(x, y);
                    rot_iter(x, y, q.ang);
                    x = gain_fix(x);
                    y = gain_fix(y);
                    if (s > 0) begin
                        h = 64'sd1 <<< (s - 1);
                        r1 = (x + h + (x < 0 ? -1 : 0)) >>> s;
                        r2 = (y + h + (y < 0 ? -1 : 0)) >>> s;
                    end else begin
                        r1 = x <<< (-s);
                        r2 = y <<< (-s);
                    end
                end
            end
            cvu_pkg::OP_ATAN: begin
                if (!(q.x == 0 && q.y == 0)) begin
                    s = norm_point(x, y);
                    r1 = vec_iter(x, y);
                end
            end
            cvu_pkg::OP_LENGTH: begin
                if (q.x == 0) r1 = magn(q.y);
                else if (q.y == 0) r1 = magn(q.x);
                else begin
                    s = norm_point(x, y);
                    dummy = vec_iter(x, y);
                    x = gain_fix(x);
                    if (s > 0) r1 = (x + (64'sd1 <<< (s - 1))) >>> s;
                    else r1 = (x & 64'hFFFF_FFFF) <<< (-s);
                end
            end
            cvu_pkg::OP_COS: r1 = cos_value(q.ang);
            cvu_pkg::OP_SIN: r1 = cos_value(ARC_Q2 - q.ang);
            default: ;
        endcase
        a.first = r1[31:0];
        a.second = r2[31:0];
        return a;
    endfunction

    function automatic longint rand_coord();
        longint v;
        case ($urandom_range(0, 9))
            0: v = 0;
            1: v = $urandom_range(0, 1) ? 64'sd1073741823 : -64'sd1073741824;
            default: v = longint'($signed(31'($urandom))) >>> $urandom_range(0, 30);
        endcase
        return v;
    endfunction

    function automatic longint rand_angle();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return $urandom_range(0, 1) ? TURN : -TURN;
            2: return longint'($urandom_range(0, 8)) * ARC_Q4 - TURN;
            default: return longint'($urandom_range(0, 47185920)) - TURN;
        endcase
    endfunction

    function automatic void add_query(logic [2:0] op, longint x, longint y, longint ang);
        t_query q;
        q.op = op; q.x = x; q.y = y; q.ang = ang;
        query_q.push_back(q);
    endfunction

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial begin
        rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.operation = '0;
        in_if.point_x = '0;
        in_if.point_y = '0;
        in_if.angle = '0;
        out_if.ready = 1'b0;
        // Directed items: bypass cases, axis points and field extremes.
        add_query(cvu_pkg::OP_ROTATE, 12345, -6789, 0);
        add_query(cvu_pkg::OP_ROTATE, 0, 0, 1000000);
        add_query(cvu_pkg::OP_ROTATE, 1073741823, -1073741824, TURN);
        add_query(cvu_pkg::OP_ROTATE, -1073741824, 1073741823, -TURN);
        add_query(cvu_pkg::OP_ROTATE, 1, 0, ARC_Q2);
        add_query(cvu_pkg::OP_ROTATE, 1073741823, 1073741823, ARC_Q4);
        add_query(cvu_pkg::OP_ATAN, 0, 0, 0);
        add_query(cvu_pkg::OP_ATAN, 1073741823, 0, 0);
        add_query(cvu_pkg::OP_ATAN, -1073741824, 0, 0);
        add_query(cvu_pkg::OP_ATAN, 0, -1, 0);
        add_query(cvu_pkg::OP_ATAN, -5, 5, 0);
        add_query(cvu_pkg::OP_LENGTH, 0, 0, 0);
        add_query(cvu_pkg::OP_LENGTH, 0, -1073741824, 0);
        add_query(cvu_pkg::OP_LENGTH, -1073741824, 0, 0);
        add_query(cvu_pkg::OP_LENGTH, 1073741823, -1073741824, 0);
        add_query(cvu_pkg::OP_LENGTH, 3, 4, 0);
        add_query(cvu_pkg::OP_COS, 0, 0, 0);
        add_query(cvu_pkg::OP_COS, 0, 0, TURN);
        add_query(cvu_pkg::OP_COS, 0, 0, -TURN);
        add_query(cvu_pkg::OP_SIN, 0, 0, ARC_Q2);
        add_query(cvu_pkg::OP_SIN, 0, 0, -ARC_HALF);
        add_query(cvu_pkg::OP_SIN, -1073741824, 1073741823, 23592959);
        for (int n = 0; n < 500; n++)
            add_query(3'($urandom_range(0, 4)), rand_coord(), rand_coord(), rand_angle());
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        forever begin
            @(negedge clk);
            if (query_q.size() == 0 && !in_if.valid && answer_q.size() == 0) break;
        end
        repeat (60) @(posedge clk);
        if (errors == 0) $display("cordic_vector_unit regression: pass");
        else $display("cordic_vector_unit regression: fail");
        $finish;
    end

    // Driver: bursts of items with random gaps in between.
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge clk) begin
        if (!rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                answer_q.push_back(cordic_predict(cur_query));
                accepted++;
            end
            if (!in_if.valid || in_if.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_if.valid <= 1'b0;
                end else if (query_q.size() > 0) begin
                    cur_query = query_q.pop_front();
                    in_if.operation <= cur_query.op;
                    in_if.point_x <= cur_query.x[30:0];
                    in_if.point_y <= cur_query.y[30:0];
                    in_if.angle <= cur_query.ang[25:0];
                    in_if.valid <= 1'b1;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(0, 40);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stall patterns; one long hold-off fills the pipeline.
    int hold_left = 0;
    bit held = 1'b0;
    int stall_mode = 0;
    always @(posedge clk) begin
        if (!rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (!held && accepted >= 150) begin
                held = 1'b1;
                hold_left = 300;
            end
            if (cycles % 64 == 0) stall_mode = $urandom_range(0, 2);
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else begin
                case (stall_mode)
                    0: out_if.ready <= 1'b1;
                    1: out_if.ready <= $urandom_range(0, 1);
                    default: out_if.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Monitor: compare each result with the oldest prediction.
    t_answer want;
    always @(posedge clk) begin
        cycles++;
        if (rst_n && out_if.valid && out_if.ready) begin
            if (answer_q.size() == 0) begin
                $display("%0t: unexpected result first=%h second=%h", $time,
                         out_if.result_first, out_if.result_second);
                errors++;
            end else begin
                want = answer_q.pop_front();
                if (out_if.result_first !== want.first) begin
                    $display("%0t: result_first expected %h actual %h", $time,
                             want.first, out_if.result_first);
                    errors++;
                end
                if (out_if.result_second !== want.second) begin
                    $display("%0t: result_second expected %h actual %h", $time,
                             want.second, out_if.result_second);
                    errors++;
                end
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout", $time);
            $display("cordic_vector_unit regression: fail");
            $finish;
        end
    end

endmodule
